// ----- hdl/llh_pkg.sv -----
// Shared constants, register indexes and item types of the latency histogram.
`default_nettype none
package llh_pkg;

  localparam int NUM_DEVICES_DEF = 3;
  localparam int NUM_BUCKETS_DEF = 12;
  localparam int COUNT_WIDTH_DEF = 32;
  localparam int QUEUE_DEPTH     = 2;

  localparam int TIME_W     = 64;
  localparam int SHIFT_W    = 5;
  localparam int INTERVAL_W = 12;
  localparam int SPAN_W     = 42;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 12;

  localparam logic [TIME_W-1:0] NS_PER_MS = 64'd1_000_000;
  localparam logic [TIME_W-1:0] NS_PER_S  = 64'd1_000_000_000;

  localparam logic [CFG_IDX_W-1:0] REG_BUCKET_SHIFT = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL     = 4'd1;

  localparam logic [SHIFT_W-1:0]    SHIFT_RST    = 5'd3;
  localparam logic [INTERVAL_W-1:0] INTERVAL_RST = 12'd10;

  typedef struct packed {
    logic [1:0]        device_index;
    logic [TIME_W-1:0] insert_ns;
    logic [TIME_W-1:0] issue_ns;
    logic [TIME_W-1:0] complete_time_ns;
  } event_t;

  typedef struct packed {
    logic [1:0]  device_number;
    logic [3:0]  bucket_number;
    logic [31:0] request_total;
    logic [31:0] queue_count;
    logic [31:0] service_count;
    logic        last_of_dump;
  } result_t;

  function automatic int dev_w(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/llh_stream_if.sv -----
// Valid/ready stream channel carrying one item of type T.
`default_nettype none
interface llh_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- hdl/llh_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module llh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 36
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- hdl/llh_front.sv -----
// Front end: config registers, event checks, window tracking and job push.
`default_nettype none
module llh_front #(
  parameter int NUM_DEVICES = llh_pkg::NUM_DEVICES_DEF,
  parameter int JOB_W       = 1 + llh_pkg::dev_w(llh_pkg::NUM_DEVICES_DEF) + 2 * llh_pkg::TIME_W
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [llh_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [llh_pkg::CFG_DATA_W-1:0] cfg_wdata,
  llh_stream_if.sink                          in_if,
  input  wire logic                           clearing,
  input  wire logic                           q_full,
  output logic                                q_push,
  output logic [JOB_W-1:0]                    q_wdata
);

  localparam int DEV_W = llh_pkg::dev_w(NUM_DEVICES);
  localparam int TW    = llh_pkg::TIME_W;

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_CHK  = 3'b010,
    F_PUSH = 3'b100
  } fstate_t;

  fstate_t                          state_r, state_nxt;
  logic [llh_pkg::SHIFT_W-1:0]      shift_r;
  logic [llh_pkg::INTERVAL_W-1:0]   interval_r;
  logic [llh_pkg::SPAN_W-1:0]       span_r;
  logic [TW-1:0]                    window_start_r;
  logic [DEV_W-1:0]                 dev_r;
  logic [TW-1:0]                    qd_r, sd_r, cmp_r, limit_r;
  logic                             ok_r;
  logic                             accept;
  logic                             dump;
  logic [TW:0]                      end_sum;
  llh_pkg::event_t                  ev;

  assign ev          = in_if.data;
  assign in_if.ready = (state_r == F_IDLE) && !clearing;
  assign accept      = in_if.valid && in_if.ready;
  assign dump        = cmp_r > limit_r;
  assign end_sum     = {1'b0, window_start_r} + (TW + 1)'(span_r);
  assign q_push      = (state_r == F_PUSH) && !q_full;
  assign q_wdata     = {dump, dev_r, qd_r, sd_r};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE: begin
        if (accept) begin
          state_nxt = F_CHK;
        end
      end
      F_CHK: begin
        state_nxt = ok_r ? F_PUSH : F_IDLE;
      end
      F_PUSH: begin
        if (!q_full) begin
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= F_IDLE;
      shift_r        <= llh_pkg::SHIFT_RST;
      interval_r     <= llh_pkg::INTERVAL_RST;
      span_r         <= llh_pkg::SPAN_W'(llh_pkg::INTERVAL_RST) *
                        llh_pkg::SPAN_W'(llh_pkg::NS_PER_S);
      window_start_r <= '0;
    end else begin
      state_r <= state_nxt;
      span_r  <= llh_pkg::SPAN_W'(interval_r) * llh_pkg::SPAN_W'(llh_pkg::NS_PER_S);
      if (cfg_we) begin
        if (cfg_index == llh_pkg::REG_BUCKET_SHIFT) begin
          shift_r <= cfg_wdata[llh_pkg::SHIFT_W-1:0];
        end else if (cfg_index == llh_pkg::REG_INTERVAL) begin
          interval_r <= cfg_wdata[llh_pkg::INTERVAL_W-1:0];
        end
      end
      if (q_push && dump) begin
        window_start_r <= cmp_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      dev_r <= DEV_W'(ev.device_index);
      ok_r  <= (32'(ev.device_index) < 32'(NUM_DEVICES)) &&
               (ev.insert_ns != '0) && (ev.issue_ns != '0) &&
               (ev.issue_ns >= ev.insert_ns);
      qd_r  <= ev.issue_ns - ev.insert_ns;
      sd_r  <= ev.complete_time_ns - ev.issue_ns;
      cmp_r <= ev.complete_time_ns;
    end else if (state_r == F_CHK) begin
      qd_r    <= qd_r >> shift_r;
      sd_r    <= sd_r >> shift_r;
      limit_r <= end_sum[TW] ? '1 : end_sum[TW-1:0];
    end
  end

endmodule
`default_nettype wire

// ----- hdl/llh_job_queue.sv -----
// Small flop FIFO of classified jobs between front and back end.
`default_nettype none
module llh_job_queue #(
  parameter int WIDTH = 131,
  parameter int DEPTH = llh_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full  = count_r == CNT_W'(DEPTH);
  assign empty = count_r == '0;
  assign rdata = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/llh_back.sv -----
// Back end: log2 bucket search, histogram update and snapshot dump.
`default_nettype none
module llh_back #(
  parameter int NUM_DEVICES = llh_pkg::NUM_DEVICES_DEF,
  parameter int NUM_BUCKETS = llh_pkg::NUM_BUCKETS_DEF,
  parameter int COUNT_WIDTH = llh_pkg::COUNT_WIDTH_DEF,
  parameter int JOB_W       = 1 + llh_pkg::dev_w(llh_pkg::NUM_DEVICES_DEF) + 2 * llh_pkg::TIME_W
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             q_empty,
  output logic                  q_pop,
  input  wire logic [JOB_W-1:0] q_rdata,
  llh_stream_if.source          out_if,
  output logic                  clearing
);

  localparam int DEV_W  = llh_pkg::dev_w(NUM_DEVICES);
  localparam int BKT_W  = $clog2(NUM_BUCKETS);
  localparam int DEPTH  = NUM_DEVICES * NUM_BUCKETS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int TW     = llh_pkg::TIME_W;
  localparam logic [BKT_W-1:0]  LAST_B = BKT_W'(NUM_BUCKETS - 1);
  localparam logic [DEV_W-1:0]  LAST_D = DEV_W'(NUM_DEVICES - 1);
  localparam logic [ADDR_W-1:0] LAST_A = ADDR_W'(DEPTH - 1);

  typedef enum logic [5:0] {
    B_CLR  = 6'b000001,
    B_IDLE = 6'b000010,
    B_BKT  = 6'b000100,
    B_WR   = 6'b001000,
    B_SCAN = 6'b010000,
    B_DUMP = 6'b100000
  } bstate_t;

  bstate_t                state_r, state_nxt;
  logic [ADDR_W-1:0]      clr_addr_r;
  logic [DEV_W-1:0]       dev_r, d_r;
  logic [BKT_W-1:0]       bq_r, bs_r, b_r;
  logic                   dump_r;
  logic [TW-1:0]          wq_r, ws_r;
  logic [COUNT_WIDTH-1:0] cnt_r [NUM_DEVICES];
  logic                   out_valid_r;
  llh_pkg::result_t       out_data_r;

  logic                   step_q, step_s, out_free, out_load, more_above;
  logic                   q_we, s_we, q_re, s_re;
  logic [ADDR_W-1:0]      q_waddr, s_waddr, q_raddr, s_raddr;
  logic [COUNT_WIDTH-1:0] q_wdata, s_wdata, q_rd, s_rd;

  function automatic logic [ADDR_W-1:0] addr_of(input logic [DEV_W-1:0] d,
                                                input logic [BKT_W-1:0] b);
    return ADDR_W'(d) * ADDR_W'(NUM_BUCKETS) + ADDR_W'(b);
  endfunction

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
    return (&c) ? c : c + COUNT_WIDTH'(1);
  endfunction

  assign clearing     = state_r == B_CLR;
  assign out_if.valid = out_valid_r;
  assign out_if.data  = out_data_r;
  assign out_free     = !out_valid_r || out_if.ready;
  assign step_q       = (bq_r != LAST_B) && (wq_r >= llh_pkg::NS_PER_MS);
  assign step_s       = (bs_r != LAST_B) && (ws_r >= llh_pkg::NS_PER_MS);

  always_comb begin
    more_above = 1'b0;
    for (int i = 0; i < NUM_DEVICES; i++) begin
      if ((i > int'(d_r)) && (cnt_r[i] != '0)) begin
        more_above = 1'b1;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    out_load  = 1'b0;
    q_we      = 1'b0;
    s_we      = 1'b0;
    q_re      = 1'b0;
    s_re      = 1'b0;
    q_waddr   = addr_of(dev_r, bq_r);
    s_waddr   = addr_of(dev_r, bs_r);
    q_raddr   = addr_of(dev_r, bq_r);
    s_raddr   = addr_of(dev_r, bs_r);
    q_wdata   = '0;
    s_wdata   = '0;
    unique case (state_r)
      B_CLR: begin
        q_we    = 1'b1;
        s_we    = 1'b1;
        q_waddr = clr_addr_r;
        s_waddr = clr_addr_r;
        if (clr_addr_r == LAST_A) begin
          state_nxt = B_IDLE;
        end
      end
      B_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          state_nxt = B_BKT;
        end
      end
      B_BKT: begin
        if (!step_q && !step_s) begin
          q_re      = 1'b1;
          s_re      = 1'b1;
          state_nxt = B_WR;
        end
      end
      B_WR: begin
        q_we      = 1'b1;
        s_we      = 1'b1;
        q_wdata   = sat_inc(q_rd);
        s_wdata   = sat_inc(s_rd);
        state_nxt = dump_r ? B_SCAN : B_IDLE;
      end
      B_SCAN: begin
        q_raddr = addr_of(d_r, '0);
        s_raddr = addr_of(d_r, '0);
        if (cnt_r[d_r] != '0) begin
          q_re      = 1'b1;
          s_re      = 1'b1;
          state_nxt = B_DUMP;
        end else if (d_r == LAST_D) begin
          state_nxt = B_IDLE;
        end
      end
      B_DUMP: begin
        q_waddr = addr_of(d_r, b_r);
        s_waddr = addr_of(d_r, b_r);
        q_raddr = addr_of(d_r, b_r + BKT_W'(1));
        s_raddr = addr_of(d_r, b_r + BKT_W'(1));
        if (out_free) begin
          out_load = 1'b1;
          q_we     = 1'b1;
          s_we     = 1'b1;
          if (b_r == LAST_B) begin
            state_nxt = (d_r == LAST_D) ? B_IDLE : B_SCAN;
          end else begin
            q_re = 1'b1;
            s_re = 1'b1;
          end
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_CLR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
      d_r         <= '0;
      b_r         <= '0;
      for (int i = 0; i < NUM_DEVICES; i++) begin
        cnt_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        B_CLR: clr_addr_r <= clr_addr_r + ADDR_W'(1);
        B_WR: begin
          cnt_r[dev_r] <= sat_inc(cnt_r[dev_r]);
          d_r          <= '0;
        end
        B_SCAN: begin
          b_r <= '0;
          if ((cnt_r[d_r] == '0) && (d_r != LAST_D)) begin
            d_r <= d_r + DEV_W'(1);
          end
        end
        B_DUMP: begin
          if (out_free) begin
            if (b_r == LAST_B) begin
              cnt_r[d_r] <= '0;
              if (d_r != LAST_D) begin
                d_r <= d_r + DEV_W'(1);
              end
            end else begin
              b_r <= b_r + BKT_W'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      dump_r <= q_rdata[JOB_W-1];
      dev_r  <= q_rdata[JOB_W-2 -: DEV_W];
      wq_r   <= q_rdata[2*TW-1 -: TW];
      ws_r   <= q_rdata[TW-1:0];
      bq_r   <= '0;
      bs_r   <= '0;
    end else if (state_r == B_BKT) begin
      if (step_q) begin
        bq_r <= bq_r + BKT_W'(1);
        wq_r <= wq_r >> 1;
      end
      if (step_s) begin
        bs_r <= bs_r + BKT_W'(1);
        ws_r <= ws_r >> 1;
      end
    end
    if (out_load) begin
      out_data_r.device_number <= 2'(d_r);
      out_data_r.bucket_number <= 4'(b_r);
      out_data_r.request_total <= 32'(cnt_r[d_r]);
      out_data_r.queue_count   <= 32'(q_rd);
      out_data_r.service_count <= 32'(s_rd);
      out_data_r.last_of_dump  <= (b_r == LAST_B) && !more_above;
    end
  end

  llh_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (DEPTH)
  ) u_queue_hist (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .re    (q_re),
    .raddr (q_raddr),
    .rdata (q_rd)
  );

  llh_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (DEPTH)
  ) u_service_hist (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .re    (s_re),
    .raddr (s_raddr),
    .rdata (s_rd)
  );

endmodule
`default_nettype wire

// ----- hdl/io_latency_log2_histogram.sv -----
// Flow: the front end checks each accepted item and pushes it into the job queue,
// then the back end updates the histograms, bounded by the serial bucket search.
// The front end takes no new item until it has pushed or dropped the last one; a
// snapshot dump scans the devices and sends one result per cycle unless stalled.
// Reset: synchronous; then a pass over the NUM_DEVICES*NUM_BUCKETS entries zeroes
// the histogram RAMs while in_if.ready stays low. Config writes are taken at once.
`default_nettype none
module io_latency_log2_histogram #(
  parameter int NUM_DEVICES = llh_pkg::NUM_DEVICES_DEF,
  parameter int NUM_BUCKETS = llh_pkg::NUM_BUCKETS_DEF,
  parameter int COUNT_WIDTH = llh_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [llh_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [llh_pkg::CFG_DATA_W-1:0] cfg_wdata,
  llh_stream_if.sink                          in_if,
  llh_stream_if.source                        out_if
);

  localparam int DEV_W = llh_pkg::dev_w(NUM_DEVICES);
  localparam int JOB_W = 1 + DEV_W + 2 * llh_pkg::TIME_W;

  logic             clearing;
  logic             q_push, q_pop, q_full, q_empty;
  logic [JOB_W-1:0] q_wdata, q_rdata;

  llh_front #(
    .NUM_DEVICES (NUM_DEVICES),
    .JOB_W       (JOB_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_if     (in_if),
    .clearing  (clearing),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  llh_job_queue #(
    .WIDTH (JOB_W),
    .DEPTH (llh_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  llh_back #(
    .NUM_DEVICES (NUM_DEVICES),
    .NUM_BUCKETS (NUM_BUCKETS),
    .COUNT_WIDTH (COUNT_WIDTH),
    .JOB_W       (JOB_W)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .q_rdata  (q_rdata),
    .out_if   (out_if),
    .clearing (clearing)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("job pushed into full queue");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("job popped from empty queue");

  a_no_input_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !in_if.ready)
    else $error("input ready during histogram clear");

endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
// Self-checking testbench of io_latency_log2_histogram: directed and random completion events.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import llh_pkg::*;

  localparam int NDEV          = NUM_DEVICES_DEF;
  localparam int NBKT          = NUM_BUCKETS_DEF;
  localparam int SETTLE_CYCLES = 100;
  localparam int STALL_LIMIT   = 3000;
  localparam int MAX_REPORTS   = 10;
  localparam int HOLD_CYCLES   = 300;

  localparam logic [TIME_W-1:0]    TIME_MAX      = '1;
  localparam logic [TIME_W-1:0]    EDGE_DONE     = 64'd50_000_000_000;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 4'd15;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  llh_stream_if #(.T(event_t))  in_ch ();
  llh_stream_if #(.T(result_t)) out_ch ();

  io_latency_log2_histogram dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_if    (in_ch),
    .out_if   (out_ch)
  );

  // expected histogram state
  logic [SHIFT_W-1:0]    exp_shift;
  logic [INTERVAL_W-1:0] exp_interval;
  logic [31:0]           queue_bins [NDEV][NBKT];
  logic [31:0]           service_bins [NDEV][NBKT];
  logic [31:0]           dev_requests [NDEV];
  logic [TIME_W-1:0]     window_start;
  result_t               expected_bins [$];

  int errors         = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_left      = 0;
  int quiet_cycles   = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [31:0] sat_inc(input logic [31:0] c);
    return (c == '1) ? c : c + 32'd1;
  endfunction

  function automatic logic [3:0] latency_bucket(input logic [TIME_W-1:0] ns);
    logic [TIME_W-1:0] v;
    int lg;
    v = (ns / NS_PER_MS) >> exp_shift;
    lg = 0;
    if (v == '0) return 4'd0;
    while (v > 64'd1) begin
      v = v >> 1;
      lg++;
    end
    return (lg + 1 > NBKT - 1) ? 4'(NBKT - 1) : 4'(lg + 1);
  endfunction

  function automatic void tally_completion(input event_t ev);
    logic [TIME_W-1:0] span;
    logic [TIME_W-1:0] limit;
    logic [3:0]        qb;
    logic [3:0]        sb;
    int                d;
    int                last_dev;
    result_t           r;
    d = int'(ev.device_index);
    if (d >= NDEV) return;
    if (ev.insert_ns == '0 || ev.issue_ns == '0 ||
        ev.issue_ns < ev.insert_ns) return;
    qb = latency_bucket(ev.issue_ns - ev.insert_ns);
    sb = latency_bucket(ev.complete_time_ns - ev.issue_ns);
    dev_requests[d]     = sat_inc(dev_requests[d]);
    queue_bins[d][qb]   = sat_inc(queue_bins[d][qb]);
    service_bins[d][sb] = sat_inc(service_bins[d][sb]);
    span  = NS_PER_S * 64'(exp_interval);
    limit = (window_start > TIME_MAX - span) ? TIME_MAX : window_start + span;
    if (ev.complete_time_ns <= limit) return;
    window_start = ev.complete_time_ns;
    last_dev = -1;
    for (int i = 0; i < NDEV; i++)
      if (dev_requests[i] != '0) last_dev = i;
    for (int i = 0; i < NDEV; i++) begin
      if (dev_requests[i] == '0) continue;
      for (int b = 0; b < NBKT; b++) begin
        r.device_number = 2'(i);
        r.bucket_number = 4'(b);
        r.request_total = dev_requests[i];
        r.queue_count   = queue_bins[i][b];
        r.service_count = service_bins[i][b];
        r.last_of_dump  = (i == last_dev) && (b == NBKT - 1);
        expected_bins.push_back(r);
        queue_bins[i][b]   = '0;
        service_bins[i][b] = '0;
      end
      dev_requests[i] = '0;
    end
  endfunction

  function automatic event_t completion(input logic [1:0] dev, input logic [TIME_W-1:0] ins,
                                        input logic [TIME_W-1:0] iss,
                                        input logic [TIME_W-1:0] cmp);
    event_t ev;
    ev.device_index     = dev;
    ev.insert_ns        = ins;
    ev.issue_ns         = iss;
    ev.complete_time_ns = cmp;
    return ev;
  endfunction

  // queue and service latencies ending at cmp
  function automatic event_t latencies(input logic [1:0] dev, input logic [TIME_W-1:0] q,
                                       input logic [TIME_W-1:0] s,
                                       input logic [TIME_W-1:0] cmp);
    return completion(dev, cmp - s - q, cmp - s, cmp);
  endfunction

  function automatic logic [TIME_W-1:0] rand_latency();
    logic [TIME_W-1:0] ms;
    case ($urandom_range(3))
      0: return 64'($urandom_range(0, 2_500_000));
      1, 2: begin
        ms = 64'($urandom) >> $urandom_range(0, 31);
        return ms * NS_PER_MS + 64'($urandom_range(0, 999_999));
      end
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic event_t random_completion(input int close_pct);
    event_t            ev;
    logic [TIME_W-1:0] span;
    logic [TIME_W-1:0] service;
    logic [TIME_W-1:0] queue_lat;
    span = NS_PER_S * 64'(exp_interval);
    ev.device_index = 2'($urandom_range(0, NDEV - 1));
    if ($urandom_range(99) < close_pct)
      ev.complete_time_ns = window_start + span + 64'd1 + 64'($urandom);
    else
      ev.complete_time_ns = window_start + ({$urandom, $urandom} % (span + 64'd1));
    service = rand_latency();
    if (service >= ev.complete_time_ns) service = ev.complete_time_ns >> 1;
    if ($urandom_range(9) == 0)
      ev.issue_ns = ev.complete_time_ns + 64'($urandom_range(1, 50_000_000));
    else
      ev.issue_ns = ev.complete_time_ns - service;
    queue_lat = rand_latency();
    if (queue_lat >= ev.issue_ns) queue_lat = ev.issue_ns >> 1;
    ev.insert_ns = ev.issue_ns - queue_lat;
    return ev;
  endfunction

  // random fields, then broken so the block must drop the item
  function automatic event_t random_noise();
    event_t ev;
    ev.device_index     = 2'($urandom);
    ev.insert_ns        = {$urandom, $urandom};
    ev.issue_ns         = {$urandom, $urandom};
    ev.complete_time_ns = {$urandom, $urandom};
    case ($urandom_range(3))
      0: ev.device_index = 2'd3;
      1: ev.insert_ns = '0;
      2: ev.issue_ns = '0;
      default: begin
        ev.issue_ns[TIME_W-1] = 1'b0;
        ev.insert_ns = ev.issue_ns + 64'($urandom_range(1, 1000));
      end
    endcase
    return ev;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_BUCKET_SHIFT) exp_shift = val[SHIFT_W-1:0];
    else if (idx == REG_INTERVAL) exp_interval = val[INTERVAL_W-1:0];
    @(posedge clk);
  endtask

  task automatic push_event(input event_t ev);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= ev;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    tally_completion(ev);
  endtask

  // stop sending, drain all expected bins, let dropped items retire
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (expected_bins.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic test_reset_defaults();
    push_event(completion(2'd0, 64'd1, 64'd1, 64'd5_000_000_000));
    push_event(completion(2'd2, 64'd1_000_000, 64'd9_000_000_000, 64'd10_000_000_001));
    settle();
  endtask

  task automatic test_dropped_events();
    logic [TIME_W-1:0] late;
    late = TIME_MAX - 64'd16;
    push_event(completion(2'd3, 64'd5, 64'd10, late));
    push_event(completion(2'd0, 64'd0, 64'd10, late));
    push_event(completion(2'd1, 64'd5, 64'd0, late));
    push_event(completion(2'd2, 64'd11, 64'd10, late));
    push_event(latencies(2'd0, 64'd2_000_000, 64'd1_000_000, 64'd20_000_000_001));
    push_event(latencies(2'd1, 64'd7, 64'd1_000_000, 64'd20_000_000_002));
    settle();
  endtask

  task automatic test_register_index();
    write_reg(REG_UNUSED_LO, 12'hFFF);
    write_reg(REG_UNUSED_HI, 12'h000);
    write_reg(4'($urandom_range(REG_UNUSED_LO, REG_UNUSED_HI)), 12'($urandom));
    push_event(completion(2'd2, 64'd1_000_000_000, 64'd2_000_000_000, 64'd30_000_000_002));
    push_event(completion(2'd1, 64'd1_000_000_000, 64'd3_000_000_000, 64'd30_000_000_003));
    settle();
  endtask

  task automatic test_bucket_edges();
    write_reg(REG_BUCKET_SHIFT, 12'd0);
    write_reg(REG_INTERVAL, 12'd0);
    push_event(latencies(2'd0, 64'd999_999, 64'd1_000_000, EDGE_DONE));
    push_event(latencies(2'd1, 64'd1_999_999, 64'd2_000_000, EDGE_DONE));
    push_event(latencies(2'd2, 64'd0, 64'd3_999_999, EDGE_DONE));
    push_event(latencies(2'd0, 64'd4_000_000, 64'd1_023_999_999, EDGE_DONE));
    push_event(latencies(2'd1, 64'd1_024_000_000, 64'd7_999_999, EDGE_DONE));
    push_event(completion(2'd2, 64'd1, TIME_MAX, EDGE_DONE));
    push_event(completion(2'd0, 64'd3, EDGE_DONE + 64'd5, EDGE_DONE));
    push_event(latencies(2'd1, 64'd2_000_000, 64'd1_500_000, EDGE_DONE + 64'd1));
    settle();
  endtask

  task automatic test_shift_extremes();
    logic [TIME_W-1:0] base;
    logic [TIME_W-1:0] close;
    write_reg(REG_BUCKET_SHIFT, 12'd16);
    write_reg(REG_INTERVAL, 12'd4095);
    base  = window_start;
    close = base + NS_PER_S * 64'd4095 + 64'd1;
    push_event(completion(2'd0, 64'd1, 64'd1 + NS_PER_MS * (64'd1 << 26), base));
    push_event(completion(2'd1, 64'd1, 64'd1 + NS_PER_MS * ((64'd1 << 26) - 64'd1), base));
    push_event(latencies(2'd2, 64'd65_536_000_000, 64'd65_535_999_999, close));
    settle();
    write_reg(REG_BUCKET_SHIFT, 12'd31);
    base  = window_start;
    close = base + NS_PER_S * 64'd4095 + 64'd1;
    push_event(completion(2'd0, 64'd1, 64'd1 + NS_PER_MS * (64'd1 << 40), base));
    push_event(completion(2'd1, 64'd1, 64'd1 + NS_PER_MS * (64'd1 << 31), base));
    push_event(completion(2'd2, 64'd1, NS_PER_MS * (64'd1 << 31), close));
    settle();
  endtask

  task automatic run_random_phase(input int send_pct, input int recv_pct, input int count);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    if ($urandom_range(4) == 0)
      write_reg(REG_BUCKET_SHIFT, 12'($urandom_range(17, 31)));
    else
      write_reg(REG_BUCKET_SHIFT, 12'($urandom_range(0, 16)));
    case ($urandom_range(4))
      0: write_reg(REG_INTERVAL, 12'd1);
      1: write_reg(REG_INTERVAL, 12'd4095);
      default: write_reg(REG_INTERVAL, 12'($urandom_range(1, 4095)));
    endcase
    for (int i = 0; i < count; i++)
      push_event(($urandom_range(5) == 0) ? random_noise() : random_completion(12));
    settle();
  endtask

  // receiver holds off while the sender keeps offering items
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = HOLD_CYCLES;
    for (int i = 0; i < 24; i++) push_event(random_completion(40));
    settle();
  endtask

  task automatic test_window_overflow();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_reg(REG_INTERVAL, 12'd1);
    push_event(completion(2'd0, 64'd1, 64'd2, TIME_MAX - 64'd5));
    push_event(completion(2'd1, 64'd1, 64'd2, TIME_MAX));
    settle();
  endtask

  initial begin : drive_ready
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin : check_bins
    result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_bins.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("unexpected bin: dev %0d bucket %0d", out_ch.data.device_number,
                   out_ch.data.bucket_number);
      end else begin
        want = expected_bins.pop_front();
        if (out_ch.data.device_number !== want.device_number ||
            out_ch.data.bucket_number !== want.bucket_number ||
            out_ch.data.request_total !== want.request_total ||
            out_ch.data.queue_count !== want.queue_count ||
            out_ch.data.service_count !== want.service_count ||
            out_ch.data.last_of_dump !== want.last_of_dump) begin
          errors++;
          if (errors <= MAX_REPORTS) begin
            $display("bin mismatch: expected dev %0d bkt %0d req %0d q %0d s %0d last %0b",
                     want.device_number, want.bucket_number, want.request_total,
                     want.queue_count, want.service_count, want.last_of_dump);
            $display("              actual   dev %0d bkt %0d req %0d q %0d s %0d last %0b",
                     out_ch.data.device_number, out_ch.data.bucket_number,
                     out_ch.data.request_total, out_ch.data.queue_count,
                     out_ch.data.service_count, out_ch.data.last_of_dump);
          end
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("io_latency_log2_histogram regression: fail");
      $finish;
    end
  end

  initial begin : regression
    exp_shift    = SHIFT_RST;
    exp_interval = INTERVAL_RST;
    window_start = '0;
    for (int d = 0; d < NDEV; d++) begin
      dev_requests[d] = '0;
      for (int b = 0; b < NBKT; b++) begin
        queue_bins[d][b]   = '0;
        service_bins[d][b] = '0;
      end
    end
    rst_n       <= 1'b0;
    cfg_we      <= 1'b0;
    cfg_index   <= '0;
    cfg_wdata   <= '0;
    in_ch.valid <= 1'b0;
    in_ch.data  <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_dropped_events();
    test_register_index();
    test_bucket_edges();
    test_shift_extremes();
    run_random_phase(0, 0, 45);
    run_random_phase(54, 0, 45);
    test_backpressure();
    run_random_phase(0, 54, 45);
    run_random_phase(12, 12, 45);
    test_window_overflow();

    if (errors == 0)
      $display("io_latency_log2_histogram regression: pass");
    else
      $display("io_latency_log2_histogram regression: fail");
    $finish;
  end

endmodule
